// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker in alrp_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ALRP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("alrp assertion failed");

// Signal holds while a request is stalled.
`define ALRP_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> $stable(sig)) \
    else $error("alrp payload changed under stall");

`endif

// ----- hdl/alrp_pkg.sv -----
// Types and constants for the absolute-loader record parser.
// No dependencies.
`default_nettype none

package alrp_pkg;

  typedef enum logic [9:0] {
    PH_HUNT   = 10'b00_0000_0001,
    PH_CNT_LO = 10'b00_0000_0010,
    PH_CNT_HI = 10'b00_0000_0100,
    PH_ADR_LO = 10'b00_0000_1000,
    PH_ADR_HI = 10'b00_0001_0000,
    PH_DAT_LO = 10'b00_0010_0000,
    PH_DAT_HI = 10'b00_0100_0000,
    PH_SUM    = 10'b00_1000_0000,
    PH_DONE   = 10'b01_0000_0000,
    PH_FAILED = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    WHY_NONE  = 2'd0,
    WHY_COUNT = 2'd1,
    WHY_SUM   = 2'd2,
    WHY_EARLY = 2'd3
  } reason_e;

  localparam logic [15:0] MinCount = 16'd6;
  localparam logic [7:0]  SumSeed  = 8'd1;
  localparam logic [7:0]  SyncLead = 8'h01;
  localparam logic [7:0]  SyncTail = 8'h00;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  previous_byte;
    logic [7:0]  running_sum;
    logic [15:0] remaining_count;
    logic [15:0] current_address;
    logic [15:0] first_address;
    logic        first_seen;
    logic        last_record;
    logic [7:0]  low_half;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    reason_e     reason;
    logic [15:0] load_address;
    logic [14:0] word_offset;
    logic [15:0] data_word;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/alrp_step.sv -----
// Next-state and result logic for one tape byte.
// Depends on alrp_pkg.
`default_nettype none

module alrp_step (
  input  alrp_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  input  logic              over_i,
  output alrp_pkg::state_t  state_o,
  output logic              res_valid_o,
  output alrp_pkg::result_t res_o
);

  logic [7:0]  sum_add;
  logic [15:0] joined;
  logic [15:0] rem_next;
  logic [15:0] diff;

  assign sum_add  = state_i.running_sum + byte_i;
  assign joined   = {byte_i, state_i.low_half};
  assign rem_next = state_i.remaining_count - 16'd2;
  assign diff     = state_i.current_address - state_i.first_address;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (state_i.phase != alrp_pkg::PH_DONE && state_i.phase != alrp_pkg::PH_FAILED) begin
      if (over_i) begin
        state_o.phase = alrp_pkg::PH_FAILED;
        res_valid_o   = 1'b1;
        res_o.kind    = alrp_pkg::KIND_FAIL;
        res_o.reason  = alrp_pkg::WHY_EARLY;
      end else begin
        if (state_i.phase != alrp_pkg::PH_HUNT) state_o.running_sum = sum_add;
        case (state_i.phase)
          alrp_pkg::PH_HUNT: begin
            if (state_i.previous_byte == alrp_pkg::SyncLead &&
                byte_i == alrp_pkg::SyncTail) begin
              state_o.running_sum = alrp_pkg::SumSeed;
              state_o.phase       = alrp_pkg::PH_CNT_LO;
            end
            state_o.previous_byte = byte_i;
          end
          alrp_pkg::PH_CNT_LO: begin
            state_o.low_half = byte_i;
            state_o.phase    = alrp_pkg::PH_CNT_HI;
          end
          alrp_pkg::PH_CNT_HI: begin
            if (joined < alrp_pkg::MinCount || joined[0]) begin
              state_o.phase = alrp_pkg::PH_FAILED;
              res_valid_o   = 1'b1;
              res_o.kind    = alrp_pkg::KIND_FAIL;
              res_o.reason  = alrp_pkg::WHY_COUNT;
            end else begin
              state_o.last_record     = (joined == alrp_pkg::MinCount);
              state_o.remaining_count = joined - alrp_pkg::MinCount;
              state_o.phase           = alrp_pkg::PH_ADR_LO;
            end
          end
          alrp_pkg::PH_ADR_LO: begin
            state_o.low_half = byte_i;
            state_o.phase    = alrp_pkg::PH_ADR_HI;
          end
          alrp_pkg::PH_ADR_HI: begin
            state_o.current_address = joined;
            if (!state_i.first_seen) begin
              state_o.first_address = joined;
              state_o.first_seen    = 1'b1;
            end
            state_o.phase = (state_i.remaining_count != 16'd0) ?
                            alrp_pkg::PH_DAT_LO : alrp_pkg::PH_SUM;
          end
          alrp_pkg::PH_DAT_LO: begin
            state_o.low_half = byte_i;
            state_o.phase    = alrp_pkg::PH_DAT_HI;
          end
          alrp_pkg::PH_DAT_HI: begin
            state_o.current_address = state_i.current_address + 16'd2;
            state_o.remaining_count = rem_next;
            state_o.phase = (rem_next != 16'd0) ? alrp_pkg::PH_DAT_LO : alrp_pkg::PH_SUM;
            res_valid_o        = 1'b1;
            res_o.kind         = alrp_pkg::KIND_DATA;
            res_o.load_address = state_i.current_address;
            res_o.word_offset  = diff[15:1];
            res_o.data_word    = joined;
          end
          alrp_pkg::PH_SUM: begin
            res_valid_o = 1'b1;
            if (sum_add != 8'd0) begin
              state_o.phase = alrp_pkg::PH_FAILED;
              res_o.kind    = alrp_pkg::KIND_FAIL;
              res_o.reason  = alrp_pkg::WHY_SUM;
            end else if (state_i.last_record) begin
              state_o.phase      = alrp_pkg::PH_DONE;
              res_o.kind         = alrp_pkg::KIND_DONE;
              res_o.load_address = state_i.current_address;
            end else begin
              res_valid_o           = 1'b0;
              state_o.previous_byte = 8'd0;
              state_o.phase         = alrp_pkg::PH_HUNT;
            end
          end
          default: begin
            state_o.phase = alrp_pkg::PH_FAILED;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/alrp_out_buf.sv -----
// Two-entry result buffer: output register plus skid register.
// Depends on alrp_pkg.
`default_nettype none

module alrp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  alrp_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output alrp_pkg::result_t out_data_o
);

  logic              head_valid_q, head_valid_d;
  logic              skid_valid_q, skid_valid_d;
  alrp_pkg::result_t head_q, head_d;
  alrp_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop         = head_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!head_valid_q || pop) begin
      head_valid_d = push_i;
      head_d       = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ----- hdl/absolute_loader_record_parser_unit.sv -----
// Latency: a result is valid in the cycle after the byte that causes it is accepted,
// later only while earlier results still wait in the result buffer.
// Throughput: one byte per cycle while the skid entry is empty; the two-entry result
// buffer keeps input flowing across a single stalled result.
// Reset: parser returns to sync hunt with all state cleared, result buffer empty.
// Depends on alrp_pkg, alrp_step, alrp_out_buf.
`default_nettype none

module absolute_loader_record_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        stream_over_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  fail_reason_o,
  output logic [15:0] load_address_o,
  output logic [14:0] word_offset_o,
  output logic [15:0] data_word_o
);

  alrp_pkg::state_t  state_q, state_d, step_state;
  alrp_pkg::result_t step_res, out_res;
  logic              step_valid;
  logic              accept;
  logic              space;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  alrp_step u_step (
    .state_i     (state_q),
    .byte_i      (stream_byte_i),
    .over_i      (stream_over_i),
    .state_o     (step_state),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  assign state_d = accept ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase:           alrp_pkg::PH_HUNT,
                   previous_byte:   8'd0,
                   running_sum:     8'd0,
                   remaining_count: 16'd0,
                   current_address: 16'd0,
                   first_address:   16'd0,
                   first_seen:      1'b0,
                   last_record:     1'b0,
                   low_half:        8'd0};
    end else begin
      state_q <= state_d;
    end
  end

  alrp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && step_valid),
    .push_data_i (step_res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign fail_reason_o  = out_res.reason;
  assign load_address_o = out_res.load_address;
  assign word_offset_o  = out_res.word_offset;
  assign data_word_o    = out_res.data_word;

endmodule

`default_nettype wire

// ----- hdl/alrp_checker.sv -----
// Port-level checker for the record parser, bound to the top level.
// Depends on assert_macros.svh and alrp_pkg.
`default_nettype none
`include "assert_macros.svh"

module alrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  stream_byte_i,
  input logic        stream_over_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [1:0]  fail_reason_o,
  input logic [15:0] load_address_o,
  input logic [14:0] word_offset_o,
  input logic [15:0] data_word_o
);

  logic terminal;
  logic in_seen;

  assign terminal = out_valid_o && result_kind_o != alrp_pkg::KIND_DATA;
  assign in_seen  = in_valid_i && in_ready_o && (stream_over_i || stream_byte_i != 8'd0 ||
                    stream_byte_i == 8'd0);

  `ALRP_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i,
    {result_kind_o, fail_reason_o, load_address_o, word_offset_o, data_word_o})
  `ALRP_ASSERT(a_last_result, clk_i, rst_ni, (terminal && out_ready_i) |=> !out_valid_o)
  `ALRP_ASSERT(a_fail_fields, clk_i, rst_ni, (out_valid_o && result_kind_o == alrp_pkg::KIND_FAIL) |-> (load_address_o == 16'd0 && data_word_o == 16'd0 && fail_reason_o != alrp_pkg::WHY_NONE))
  `ALRP_ASSERT(a_data_no_reason, clk_i, rst_ni, (out_valid_o && result_kind_o != alrp_pkg::KIND_FAIL) |-> (fail_reason_o == alrp_pkg::WHY_NONE && (result_kind_o == alrp_pkg::KIND_DATA || result_kind_o == alrp_pkg::KIND_DONE)))
  `ALRP_ASSERT(a_ready_after_pop, clk_i, rst_ni, (in_seen && !out_valid_o) |=> in_ready_o)

endmodule

bind absolute_loader_record_parser_unit alrp_checker u_alrp_checker (.*);

`default_nettype wire

// ----- dv/alrp_load_monitor.sv -----
// Monitor for the absolute-loader record parser: predicts each result from
// the accepted tape bytes and compares every result field by field.
// Depends on alrp_pkg.
module alrp_load_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        stream_over_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  result_kind_i,
  input  logic [1:0]  fail_reason_i,
  input  logic [15:0] load_address_i,
  input  logic [14:0] word_offset_i,
  input  logic [15:0] data_word_i,
  output int          bad_fields_o,
  output int          results_due_o
);

  alrp_pkg::phase_e  parse_phase;
  logic [7:0]        prior_byte;
  logic [7:0]        tape_sum;
  logic [7:0]        half_byte;
  logic [15:0]       bytes_left;
  logic [15:0]       word_addr;
  logic [15:0]       origin_addr;
  logic              origin_known;
  logic              final_record;

  alrp_pkg::result_t loader_results_due[$];
  alrp_pkg::result_t due;
  alrp_pkg::result_t fresh;
  int                mismatches;

  function automatic bit parse_tape_byte(input logic [7:0] b, input logic over,
                                         output alrp_pkg::result_t res);
    logic [15:0] joined;
    logic [15:0] span;
    bit          emitted;
    res = '0;
    emitted = 1'b0;
    joined = {b, half_byte};
    if (parse_phase == alrp_pkg::PH_DONE || parse_phase == alrp_pkg::PH_FAILED) begin
      return 1'b0;
    end
    if (over) begin
      parse_phase = alrp_pkg::PH_FAILED;
      res.kind = alrp_pkg::KIND_FAIL;
      res.reason = alrp_pkg::WHY_EARLY;
      return 1'b1;
    end
    if (parse_phase != alrp_pkg::PH_HUNT) tape_sum = tape_sum + b;
    case (parse_phase)
      alrp_pkg::PH_HUNT: begin
        if (prior_byte == alrp_pkg::SyncLead && b == alrp_pkg::SyncTail) begin
          tape_sum = alrp_pkg::SumSeed;
          parse_phase = alrp_pkg::PH_CNT_LO;
        end
        prior_byte = b;
      end
      alrp_pkg::PH_CNT_LO: begin
        half_byte = b;
        parse_phase = alrp_pkg::PH_CNT_HI;
      end
      alrp_pkg::PH_CNT_HI: begin
        if (joined < alrp_pkg::MinCount || joined[0]) begin
          parse_phase = alrp_pkg::PH_FAILED;
          res.kind = alrp_pkg::KIND_FAIL;
          res.reason = alrp_pkg::WHY_COUNT;
          emitted = 1'b1;
        end else begin
          final_record = (joined == alrp_pkg::MinCount);
          bytes_left = joined - alrp_pkg::MinCount;
          parse_phase = alrp_pkg::PH_ADR_LO;
        end
      end
      alrp_pkg::PH_ADR_LO: begin
        half_byte = b;
        parse_phase = alrp_pkg::PH_ADR_HI;
      end
      alrp_pkg::PH_ADR_HI: begin
        word_addr = joined;
        if (!origin_known) begin
          origin_addr = joined;
          origin_known = 1'b1;
        end
        parse_phase = (bytes_left != 16'd0) ? alrp_pkg::PH_DAT_LO : alrp_pkg::PH_SUM;
      end
      alrp_pkg::PH_DAT_LO: begin
        half_byte = b;
        parse_phase = alrp_pkg::PH_DAT_HI;
      end
      alrp_pkg::PH_DAT_HI: begin
        span = word_addr - origin_addr;
        res.kind = alrp_pkg::KIND_DATA;
        res.load_address = word_addr;
        res.word_offset = span[15:1];
        res.data_word = joined;
        emitted = 1'b1;
        word_addr = word_addr + 16'd2;
        bytes_left = bytes_left - 16'd2;
        parse_phase = (bytes_left != 16'd0) ? alrp_pkg::PH_DAT_LO : alrp_pkg::PH_SUM;
      end
      alrp_pkg::PH_SUM: begin
        if (tape_sum != 8'd0) begin
          parse_phase = alrp_pkg::PH_FAILED;
          res.kind = alrp_pkg::KIND_FAIL;
          res.reason = alrp_pkg::WHY_SUM;
          emitted = 1'b1;
        end else if (final_record) begin
          parse_phase = alrp_pkg::PH_DONE;
          res.kind = alrp_pkg::KIND_DONE;
          res.load_address = word_addr;
          emitted = 1'b1;
        end else begin
          prior_byte = 8'd0;
          parse_phase = alrp_pkg::PH_HUNT;
        end
      end
      default: parse_phase = alrp_pkg::PH_FAILED;
    endcase
    return emitted;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_phase = alrp_pkg::PH_HUNT;
      prior_byte = '0;
      tape_sum = '0;
      half_byte = '0;
      bytes_left = '0;
      word_addr = '0;
      origin_addr = '0;
      origin_known = 1'b0;
      final_record = 1'b0;
      loader_results_due.delete();
      mismatches = 0;
      bad_fields_o <= 0;
      results_due_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (loader_results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, got kind %0d address %h word %h",
                   $time, result_kind_i, load_address_i, data_word_i);
        end else begin
          due = loader_results_due.pop_front();
          compare_field("result_kind", due.kind, result_kind_i);
          compare_field("fail_reason", due.reason, fail_reason_i);
          compare_field("load_address", due.load_address, load_address_i);
          compare_field("word_offset", due.word_offset, word_offset_i);
          compare_field("data_word", due.data_word, data_word_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_tape_byte(stream_byte_i, stream_over_i, fresh)) begin
          loader_results_due.push_back(fresh);
        end
      end
      bad_fields_o <= mismatches;
      results_due_o <= loader_results_due.size();
    end
  end

endmodule

// ----- dv/absolute_loader_record_parser_unit_tb.sv -----
// Top for the absolute-loader record parser: builds one long tape image of
// sync noise and load records, plays it under random gaps and output stalls.
// Depends on alrp_pkg, absolute_loader_record_parser_unit, alrp_load_monitor.
module absolute_loader_record_parser_unit_tb;

  localparam int          TapeItems     = 1400;
  localparam int          IdleLimit     = 2000;
  localparam logic [15:0] FirstLoadAddr = 16'hFFFE;

  typedef struct packed {
    logic [7:0] value;
    logic       over;
  } tape_item_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  stream_byte_i = '0;
  logic        stream_over_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  result_kind_o;
  logic [1:0]  fail_reason_o;
  logic [15:0] load_address_o;
  logic [14:0] word_offset_o;
  logic [15:0] data_word_o;

  int          bad_fields;
  int          results_due;

  tape_item_t  tape[$];
  logic [15:0] record_words[$];
  logic [15:0] next_addr = FirstLoadAddr;
  ready_mode_e ready_mode = READY_ALWAYS;
  int          mode_left = 0;

  absolute_loader_record_parser_unit dut (.*);

  alrp_load_monitor monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .stream_over_i (stream_over_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_i (result_kind_o),
    .fail_reason_i (fail_reason_o),
    .load_address_i(load_address_o),
    .word_offset_i (word_offset_o),
    .data_word_i   (data_word_o),
    .bad_fields_o  (bad_fields),
    .results_due_o (results_due)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic push_byte(input logic [7:0] value, input logic over = 1'b0);
    tape.push_back('{value, over});
  endtask

  // Hunt-phase garbage that never forms the sync pair on its own.
  task automatic push_noise(input int n);
    logic [7:0] prev;
    logic [7:0] b;
    prev = 8'h00;
    repeat (n) begin
      b = ($urandom_range(0, 3) == 0) ? alrp_pkg::SyncLead : 8'($urandom);
      if (prev == alrp_pkg::SyncLead && b == alrp_pkg::SyncTail) b = 8'h02;
      push_byte(b);
      prev = b;
    end
  endtask

  // Words come from record_words while it holds any, else at random.
  task automatic push_record(input logic [15:0] addr, input int words,
                             input bit spoil_sum);
    logic [15:0] cnt;
    logic [15:0] w;
    logic [7:0]  sum;
    logic [7:0]  chk;
    cnt = alrp_pkg::MinCount + 16'(2 * words);
    sum = alrp_pkg::SumSeed + cnt[7:0] + cnt[15:8] + addr[7:0] + addr[15:8];
    push_byte(alrp_pkg::SyncLead);
    push_byte(alrp_pkg::SyncTail);
    push_byte(cnt[7:0]);
    push_byte(cnt[15:8]);
    push_byte(addr[7:0]);
    push_byte(addr[15:8]);
    repeat (words) begin
      w = (record_words.size() != 0) ? record_words.pop_front() : 16'($urandom);
      sum = sum + w[7:0] + w[15:8];
      push_byte(w[7:0]);
      push_byte(w[15:8]);
    end
    chk = 8'h00 - sum;
    if (spoil_sum) chk = chk + 8'($urandom_range(1, 255));
    push_byte(chk);
    next_addr = addr + 16'(2 * words);
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 4))
      0: return next_addr;
      1: return FirstLoadAddr - 16'(2 * $urandom_range(1, 40));
      2: return 16'hFFFE - 16'(2 * $urandom_range(0, 4));
      3: return FirstLoadAddr + 16'(2 * $urandom_range(0, 200));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic play_tape();
    int burst;
    int gap;
    while (tape.size() != 0) begin
      burst = $urandom_range(1, 40);
      while (burst != 0 && tape.size() != 0) begin
        in_valid_i <= 1'b1;
        stream_byte_i <= tape[0].value;
        stream_over_i <= tape[0].over;
        do @(posedge clk_i); while (!in_ready_o);
        void'(tape.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_COIN: out_ready_i <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
      default: out_ready_i <= (mode_left % 4 != 0);
    endcase
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int          words;
    int          cut;
    logic [15:0] bad_count;

    // lead byte with a stray between, then repeated lead bytes before sync
    push_byte(alrp_pkg::SyncLead);
    push_byte(8'h05);
    push_byte(alrp_pkg::SyncTail);
    push_byte(8'hFF);
    push_byte(alrp_pkg::SyncLead);
    push_byte(alrp_pkg::SyncLead);
    // first record at the top of memory; its second word wraps to zero
    record_words = '{16'hFFFF, 16'h0000};
    push_record(FirstLoadAddr, 2, 1'b0);
    // just below the first record: largest offset
    record_words = '{16'h8001};
    push_record(FirstLoadAddr - 16'd2, 1, 1'b0);

    while (tape.size() < TapeItems) begin
      push_noise(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      words = ($urandom_range(0, 39) == 0) ? $urandom_range(125, 180)
                                           : $urandom_range(1, 12);
      push_record(pick_address(), words, 1'b0);
    end

    // the load ends once per run; the seed picks how
    push_noise($urandom_range(0, 4));
    case ($urandom_range(0, 3))
      0: push_record(pick_address(), 0, 1'b0);
      1: begin
        bad_count = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 5))
                                                : (16'($urandom) | 16'h0001);
        push_byte(alrp_pkg::SyncLead);
        push_byte(alrp_pkg::SyncTail);
        push_byte(bad_count[7:0]);
        push_byte(bad_count[15:8]);
      end
      2: push_record(pick_address(), $urandom_range(0, 4), 1'b1);
      default: begin
        words = $urandom_range(0, 3);
        push_record(pick_address(), words, 1'b0);
        cut = $urandom_range(1, 7 + 2 * words);
        repeat (cut) void'(tape.pop_back());
        push_byte(8'($urandom), 1'b1);
      end
    endcase
    // ignored after the load has ended
    push_byte(alrp_pkg::SyncLead);
    push_byte(alrp_pkg::SyncTail);
    push_byte(8'h06);
    push_byte(8'h00);
    push_byte(8'($urandom), 1'b1);
    push_byte(8'hFF);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    play_tape();
    while (results_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bad_fields == 0 && results_due == 0) begin
      $display("SUCCESS");
    end else begin
      if (results_due != 0) $display("%0t: %0d results never arrived", $time, results_due);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
